/* rtl/core/assert_macros.svh */
// Assertion macros used by the lane gap speed classifier tracker.
// With SYNTH defined every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The expression must hold at every clock edge outside reset.
`define LGSC_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("%m: assertion failed");
// When the trigger holds, the consequence must hold in the next cycle.
`define LGSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define LGSC_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define LGSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/core/lgsc_pkg.sv */
// Shared types and constants of the lane gap speed classifier.
// No dependencies; every RTL module imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lgsc_pkg;

    localparam int CFG_DATA_W   = 13;
    localparam int FRAME_NUM_W  = 24;
    localparam int LEVEL_W      = 8;
    localparam int COUNT_W      = 8;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_FAST_GAP_THR  = 3'd2,
        REG_SAT_LIMIT     = 3'd3,
        REG_VALUE_SENS    = 3'd4
    } cfg_index_t;

    localparam logic [CFG_DATA_W-1:0] RESET_FRAME_WIDTH  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] RESET_FRAME_HEIGHT = 13'd480;
    localparam logic [COUNT_W-1:0]    RESET_FAST_GAP_THR = 8'd4;
    localparam logic [LEVEL_W-1:0]    RESET_SAT_LIMIT    = 8'd70;
    localparam logic [LEVEL_W-1:0]    RESET_VALUE_SENS   = 8'd130;

    localparam logic [CFG_DATA_W-1:0] MIN_FRAME_WIDTH  = 13'd2;
    localparam logic [CFG_DATA_W-1:0] MIN_FRAME_HEIGHT = 13'd5;

    // Reciprocals for 2h/3 and 4h/5; exact for dividends below 2**17.
    localparam logic [15:0] RECIP_3 = 16'd43691;
    localparam int          SHIFT_3 = 17;
    localparam logic [15:0] RECIP_5 = 16'd52429;
    localparam int          SHIFT_5 = 18;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        SPEED_UNCHANGED = 2'd0,
        SPEED_SLOW      = 2'd1,
        SPEED_NORMAL    = 2'd2,
        SPEED_FAST      = 2'd3
    } speed_class_t;

    // Per-pixel flags handed from the input stage to the tracker.
    typedef struct packed {
        logic white;
        logic window_hit;
    } pixel_flags_t;

endpackage

`default_nettype wire

/* rtl/core/lgsc_config.sv */
// Configuration registers and the frame geometry derived from them.
// Depends on lgsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgsc_config #(
    parameter int MAX_FRAME_SIDE = 4096
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [2:0]                          cfg_addr,
    input  wire logic [lgsc_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    output logic [$clog2(MAX_FRAME_SIDE)-1:0]        col_last,
    output logic [$clog2(MAX_FRAME_SIDE)-1:0]        col_half,
    output logic [$clog2(MAX_FRAME_SIDE):0]          col_right_end,
    output logic [$clog2(MAX_FRAME_SIDE)-1:0]        row_last,
    output logic [$clog2(MAX_FRAME_SIDE)-1:0]        row_low,
    output logic [$clog2(MAX_FRAME_SIDE)-1:0]        row_high,
    output logic [lgsc_pkg::COUNT_W-1:0]             fast_gap_thr,
    output logic [lgsc_pkg::LEVEL_W-1:0]             sat_limit,
    output logic [lgsc_pkg::LEVEL_W-1:0]             value_sens
);
    import lgsc_pkg::*;

    localparam int POS_W  = $clog2(MAX_FRAME_SIDE);
    localparam int SIDE_W = POS_W + 1;
    localparam logic [CFG_DATA_W:0] MAX_SIDE = (CFG_DATA_W+1)'(MAX_FRAME_SIDE);

    function automatic logic [SIDE_W-1:0] clamp_side(
        input logic [CFG_DATA_W-1:0] raw,
        input logic [CFG_DATA_W-1:0] lo
    );
        logic [CFG_DATA_W:0] v;
        v = {1'b0, raw};
        if (raw < lo) begin
            v = {1'b0, lo};
        end else if (v > MAX_SIDE) begin
            v = MAX_SIDE;
        end
        return SIDE_W'(v);
    endfunction

    function automatic logic [POS_W-1:0] side_last(input logic [SIDE_W-1:0] side);
        return POS_W'(side - SIDE_W'(1));
    endfunction

    function automatic logic [POS_W-1:0] rows_low(input logic [SIDE_W-1:0] side);
        logic [31:0] prod;
        prod = (32'(side) << 1) * 32'(RECIP_3);
        return POS_W'(prod >> SHIFT_3);
    endfunction

    function automatic logic [POS_W-1:0] rows_high(input logic [SIDE_W-1:0] side);
        logic [31:0] prod;
        prod = (32'(side) << 2) * 32'(RECIP_5);
        return POS_W'(prod >> SHIFT_5);
    endfunction

    logic [SIDE_W-1:0] wr_width;
    logic [SIDE_W-1:0] wr_height;
    logic [SIDE_W-1:0] rst_width;
    logic [SIDE_W-1:0] rst_height;

    logic [POS_W-1:0]   col_last_reg;
    logic [POS_W-1:0]   col_half_reg;
    logic [SIDE_W-1:0]  col_right_end_reg;
    logic [POS_W-1:0]   row_last_reg;
    logic [POS_W-1:0]   row_low_reg;
    logic [POS_W-1:0]   row_high_reg;
    logic [COUNT_W-1:0] fast_gap_thr_reg;
    logic [LEVEL_W-1:0] sat_limit_reg;
    logic [LEVEL_W-1:0] value_sens_reg;

    assign wr_width   = clamp_side(cfg_wr_data, MIN_FRAME_WIDTH);
    assign wr_height  = clamp_side(cfg_wr_data, MIN_FRAME_HEIGHT);
    assign rst_width  = clamp_side(RESET_FRAME_WIDTH, MIN_FRAME_WIDTH);
    assign rst_height = clamp_side(RESET_FRAME_HEIGHT, MIN_FRAME_HEIGHT);

    // The geometry is derived once, when the size is written, so the pixel
    // path sees only compares against registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_last_reg      <= side_last(rst_width);
            col_half_reg      <= POS_W'(rst_width >> 1);
            col_right_end_reg <= rst_width & ~SIDE_W'(1);
            row_last_reg      <= side_last(rst_height);
            row_low_reg       <= rows_low(rst_height);
            row_high_reg      <= rows_high(rst_height);
            fast_gap_thr_reg  <= RESET_FAST_GAP_THR;
            sat_limit_reg     <= RESET_SAT_LIMIT;
            value_sens_reg    <= RESET_VALUE_SENS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_addr))
                REG_FRAME_WIDTH: begin
                    col_last_reg      <= side_last(wr_width);
                    col_half_reg      <= POS_W'(wr_width >> 1);
                    col_right_end_reg <= wr_width & ~SIDE_W'(1);
                end
                REG_FRAME_HEIGHT: begin
                    row_last_reg <= side_last(wr_height);
                    row_low_reg  <= rows_low(wr_height);
                    row_high_reg <= rows_high(wr_height);
                end
                REG_FAST_GAP_THR: fast_gap_thr_reg <= cfg_wr_data[COUNT_W-1:0];
                REG_SAT_LIMIT:    sat_limit_reg    <= cfg_wr_data[LEVEL_W-1:0];
                REG_VALUE_SENS:   value_sens_reg   <= cfg_wr_data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign col_last      = col_last_reg;
    assign col_half      = col_half_reg;
    assign col_right_end = col_right_end_reg;
    assign row_last      = row_last_reg;
    assign row_low       = row_low_reg;
    assign row_high      = row_high_reg;
    assign fast_gap_thr  = fast_gap_thr_reg;
    assign sat_limit     = sat_limit_reg;
    assign value_sens    = value_sens_reg;

endmodule

`default_nettype wire

/* rtl/core/lgsc_pixel_eval.sv */
// Per-pixel white test and frame window test on the incoming word.
// Depends on lgsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgsc_pixel_eval #(
    parameter int FRAME_WINDOW = 20
) (
    input  wire logic [lgsc_pkg::LEVEL_W-1:0]     blue_level,
    input  wire logic [lgsc_pkg::LEVEL_W-1:0]     green_level,
    input  wire logic [lgsc_pkg::LEVEL_W-1:0]     red_level,
    input  wire logic [lgsc_pkg::FRAME_NUM_W-1:0] frame_number,
    input  wire logic [lgsc_pkg::LEVEL_W-1:0]     sat_limit,
    input  wire logic [lgsc_pkg::LEVEL_W-1:0]     value_sens,
    output lgsc_pkg::pixel_flags_t                flags
);
    import lgsc_pkg::*;

    function automatic int trailing_zeros(input int v);
        int n;
        n = 0;
        for (int i = 0; i < 8; i++) begin
            if (((v >> i) & 1) == 0 && n == i) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    // Inverse of an odd number modulo 2**24 by Newton iteration.
    function automatic logic [FRAME_NUM_W-1:0] odd_inverse(input int d);
        logic [FRAME_NUM_W-1:0] x;
        logic [FRAME_NUM_W-1:0] dv;
        dv = FRAME_NUM_W'(d);
        x  = dv;
        for (int i = 0; i < 5; i++) begin
            x = x * (FRAME_NUM_W'(2) - dv * x);
        end
        return x;
    endfunction

    // Divisibility by FRAME_WINDOW = 2**TZ * ODD: the low TZ bits are zero and
    // the rest times the inverse of ODD lands at or below the quotient bound.
    localparam int TZ  = trailing_zeros(FRAME_WINDOW);
    localparam int ODD = FRAME_WINDOW >> TZ;
    localparam logic [FRAME_NUM_W-1:0] INV       = odd_inverse(ODD);
    localparam logic [FRAME_NUM_W-1:0] DIV_BOUND = FRAME_NUM_W'((2 ** FRAME_NUM_W - 1) / ODD);
    localparam logic [FRAME_NUM_W-1:0] TZ_MASK   = FRAME_NUM_W'((32'd1 << TZ) - 32'd1);

    logic [LEVEL_W-1:0]     hi;
    logic [LEVEL_W-1:0]     lo;
    logic [LEVEL_W-1:0]     diff;
    logic [17:0]            sat_lhs;
    logic [17:0]            sat_rhs;
    logic                   sat_ok;
    logic                   value_ok;
    logic [FRAME_NUM_W-1:0] frame_odd;
    logic [FRAME_NUM_W-1:0] frame_check;

    always_comb begin
        hi = blue_level;
        lo = blue_level;
        if (green_level > hi) hi = green_level;
        if (red_level > hi)   hi = red_level;
        if (green_level < lo) lo = green_level;
        if (red_level < lo)   lo = red_level;
    end

    assign diff = hi - lo;

    // Rounded 255*diff/hi below the limit, cross-multiplied.
    assign sat_lhs = 18'({diff, 9'b0}) - 18'({diff, 1'b0}) + 18'(hi);
    assign sat_rhs = 18'({16'(sat_limit * hi), 1'b0});
    assign sat_ok  = (hi == '0) ? (sat_limit != '0) : (sat_lhs < sat_rhs);

    assign value_ok = (9'(hi) + 9'(value_sens)) > 9'(LEVEL_MAX);

    assign frame_odd   = frame_number >> TZ;
    assign frame_check = FRAME_NUM_W'(frame_odd * INV);

    assign flags.white      = sat_ok && value_ok;
    assign flags.window_hit = ((frame_number & TZ_MASK) == '0) && (frame_check <= DIV_BOUND);

endmodule

`default_nettype wire

/* rtl/core/lgsc_tracker.sv */
// Raster position, per-half lane tracking, gap counters and result register.
// Depends on lgsc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lgsc_tracker #(
    parameter int MAX_FRAME_SIDE = 4096
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               pix_valid,
    input  wire lgsc_pkg::pixel_flags_t             pix_flags,
    output logic                                    pix_take,
    input  wire logic [$clog2(MAX_FRAME_SIDE)-1:0]  col_last,
    input  wire logic [$clog2(MAX_FRAME_SIDE)-1:0]  col_half,
    input  wire logic [$clog2(MAX_FRAME_SIDE):0]    col_right_end,
    input  wire logic [$clog2(MAX_FRAME_SIDE)-1:0]  row_last,
    input  wire logic [$clog2(MAX_FRAME_SIDE)-1:0]  row_low,
    input  wire logic [$clog2(MAX_FRAME_SIDE)-1:0]  row_high,
    input  wire logic [lgsc_pkg::COUNT_W-1:0]       fast_gap_thr,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [1:0]                              m_speed_class,
    output logic [lgsc_pkg::COUNT_W-1:0]            m_max_gap_count,
    output logic                                    m_left_lane_seen,
    output logic                                    m_right_lane_seen
);
    import lgsc_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_SIDE);

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
    endfunction

    logic [POS_W-1:0]   col_reg, col_next;
    logic [POS_W-1:0]   row_reg, row_next;
    logic               left_found_reg, left_found_next;
    logic               right_found_reg, right_found_next;
    logic               left_present_reg, left_present_next;
    logic               right_present_reg, right_present_next;
    logic [COUNT_W-1:0] left_gap_reg, left_gap_next;
    logic [COUNT_W-1:0] right_gap_reg, right_gap_next;
    logic               m_valid_reg, m_valid_next;
    speed_class_t       class_reg, class_next;
    logic [COUNT_W-1:0] max_gap_reg, max_gap_next;
    logic               left_seen_reg, left_seen_next;
    logic               right_seen_reg, right_seen_next;

    logic               in_rows;
    logic               hit_left;
    logic               hit_right;
    logic               last_col;
    logic               last_row;
    logic               frame_end;
    logic               left_seen;
    logic               right_seen;
    logic [COUNT_W-1:0] left_bumped;
    logic [COUNT_W-1:0] right_bumped;
    logic [COUNT_W-1:0] max_gap;

    assign in_rows   = (row_reg >= row_low) && (row_reg < row_high) && pix_flags.white;
    assign hit_left  = in_rows && (col_reg < col_half);
    assign hit_right = in_rows && !(col_reg < col_half) && ({1'b0, col_reg} < col_right_end);
    assign last_col  = col_reg >= col_last;
    assign last_row  = row_reg >= row_last;
    assign frame_end = last_col && last_row;

    // A pixel that closes no frame always moves on; a frame's last pixel
    // waits until the result register is free.
    assign pix_take = pix_valid && (!frame_end || !m_valid_reg || m_ready);

    assign left_seen    = left_found_reg || hit_left;
    assign right_seen   = right_found_reg || hit_right;
    assign left_bumped  = (!left_seen && left_present_reg) ? bump(left_gap_reg) : left_gap_reg;
    assign right_bumped = (!right_seen && right_present_reg) ? bump(right_gap_reg)
                                                             : right_gap_reg;
    assign max_gap      = (right_bumped > left_bumped) ? right_bumped : left_bumped;

    always_comb begin
        col_next           = col_reg;
        row_next           = row_reg;
        left_found_next    = left_found_reg;
        right_found_next   = right_found_reg;
        left_present_next  = left_present_reg;
        right_present_next = right_present_reg;
        left_gap_next      = left_gap_reg;
        right_gap_next     = right_gap_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        class_next         = class_reg;
        max_gap_next       = max_gap_reg;
        left_seen_next     = left_seen_reg;
        right_seen_next    = right_seen_reg;

        if (pix_take) begin
            left_found_next  = left_seen;
            right_found_next = right_seen;
            if (!last_col) begin
                col_next = col_reg + POS_W'(1);
            end else begin
                col_next = '0;
                if (!last_row) begin
                    row_next = row_reg + POS_W'(1);
                end else begin
                    row_next           = '0;
                    left_found_next    = 1'b0;
                    right_found_next   = 1'b0;
                    left_present_next  = left_seen;
                    right_present_next = right_seen;
                    m_valid_next       = 1'b1;
                    left_seen_next     = left_seen;
                    right_seen_next    = right_seen;
                    if (pix_flags.window_hit) begin
                        left_gap_next  = '0;
                        right_gap_next = '0;
                        max_gap_next   = max_gap;
                        if (max_gap == '0) begin
                            class_next = SPEED_SLOW;
                        end else if (max_gap < fast_gap_thr) begin
                            class_next = SPEED_NORMAL;
                        end else begin
                            class_next = SPEED_FAST;
                        end
                    end else begin
                        left_gap_next  = left_bumped;
                        right_gap_next = right_bumped;
                        max_gap_next   = '0;
                        class_next     = SPEED_UNCHANGED;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg           <= '0;
            row_reg           <= '0;
            left_found_reg    <= 1'b0;
            right_found_reg   <= 1'b0;
            left_present_reg  <= 1'b1;
            right_present_reg <= 1'b1;
            left_gap_reg      <= '0;
            right_gap_reg     <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            col_reg           <= col_next;
            row_reg           <= row_next;
            left_found_reg    <= left_found_next;
            right_found_reg   <= right_found_next;
            left_present_reg  <= left_present_next;
            right_present_reg <= right_present_next;
            left_gap_reg      <= left_gap_next;
            right_gap_reg     <= right_gap_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        class_reg      <= class_next;
        max_gap_reg    <= max_gap_next;
        left_seen_reg  <= left_seen_next;
        right_seen_reg <= right_seen_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_speed_class     = class_reg;
    assign m_max_gap_count   = max_gap_reg;
    assign m_left_lane_seen  = left_seen_reg;
    assign m_right_lane_seen = right_seen_reg;

    `LGSC_ASSERT_NEXT(a_frame_end_gives_word, aclk, aresetn, pix_take && frame_end, m_valid_reg)
    `LGSC_ASSERT_NEXT(a_presence_follows_seen, aclk, aresetn, pix_take && frame_end,
        left_present_reg == left_seen_reg && right_present_reg == right_seen_reg)
    `LGSC_ASSERT_NEXT(a_window_clears_counts, aclk, aresetn,
        pix_take && frame_end && pix_flags.window_hit, left_gap_reg == '0 && right_gap_reg == '0)
    `LGSC_ASSERT_NEXT(a_frame_restarts, aclk, aresetn, pix_take && frame_end,
        col_reg == '0 && row_reg == '0 && !left_found_reg && !right_found_reg)

endmodule

`default_nettype wire

/* rtl/core/lane_gap_speed_classifier_unit.sv */
// Lane gap speed classifier: one BGR pixel word per cycle, one result word per frame;
// a frame's last pixel stalls the input while the previous result word is still held.
// Once taken, the last pixel's result is written straight into the result register.
// Throughput: one pixel per cycle outside such stalls, set by the position and lane update.
// Reset (aresetn, synchronous, active low) restores the register defaults and clears
// positions and counters at once; no clearing pass follows.
`timescale 1ns / 1ps
`default_nettype none

module lane_gap_speed_classifier_unit #(
    parameter int FRAME_WINDOW   = 20,
    parameter int MAX_FRAME_SIDE = 4096
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [2:0]                       cfg_addr,
    input  wire logic [lgsc_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [lgsc_pkg::LEVEL_W-1:0]     s_blue_level,
    input  wire logic [lgsc_pkg::LEVEL_W-1:0]     s_green_level,
    input  wire logic [lgsc_pkg::LEVEL_W-1:0]     s_red_level,
    input  wire logic [lgsc_pkg::FRAME_NUM_W-1:0] s_frame_number,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [1:0]                            m_speed_class,
    output logic [lgsc_pkg::COUNT_W-1:0]          m_max_gap_count,
    output logic                                  m_left_lane_seen,
    output logic                                  m_right_lane_seen
);
    import lgsc_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_SIDE);

    logic [POS_W-1:0]   col_last;
    logic [POS_W-1:0]   col_half;
    logic [POS_W:0]     col_right_end;
    logic [POS_W-1:0]   row_last;
    logic [POS_W-1:0]   row_low;
    logic [POS_W-1:0]   row_high;
    logic [COUNT_W-1:0] fast_gap_thr;
    logic [LEVEL_W-1:0] sat_limit;
    logic [LEVEL_W-1:0] value_sens;

    pixel_flags_t flags_next;
    pixel_flags_t flags_reg;
    logic         in_valid_reg;
    logic         pix_take;

    lgsc_config #(
        .MAX_FRAME_SIDE(MAX_FRAME_SIDE)
    ) u_config (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .col_last      (col_last),
        .col_half      (col_half),
        .col_right_end (col_right_end),
        .row_last      (row_last),
        .row_low       (row_low),
        .row_high      (row_high),
        .fast_gap_thr  (fast_gap_thr),
        .sat_limit     (sat_limit),
        .value_sens    (value_sens)
    );

    lgsc_pixel_eval #(
        .FRAME_WINDOW(FRAME_WINDOW)
    ) u_pixel_eval (
        .blue_level   (s_blue_level),
        .green_level  (s_green_level),
        .red_level    (s_red_level),
        .frame_number (s_frame_number),
        .sat_limit    (sat_limit),
        .value_sens   (value_sens),
        .flags        (flags_next)
    );

    // The input register takes a new word when it is empty or its current one moves on.
    assign s_ready = !in_valid_reg || pix_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (pix_take) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            flags_reg <= flags_next;
        end
    end

    lgsc_tracker #(
        .MAX_FRAME_SIDE(MAX_FRAME_SIDE)
    ) u_tracker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .pix_valid         (in_valid_reg),
        .pix_flags         (flags_reg),
        .pix_take          (pix_take),
        .col_last          (col_last),
        .col_half          (col_half),
        .col_right_end     (col_right_end),
        .row_last          (row_last),
        .row_low           (row_low),
        .row_high          (row_high),
        .fast_gap_thr      (fast_gap_thr),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_speed_class     (m_speed_class),
        .m_max_gap_count   (m_max_gap_count),
        .m_left_lane_seen  (m_left_lane_seen),
        .m_right_lane_seen (m_right_lane_seen)
    );

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for lane_gap_speed_classifier_unit: streams BGR pixel words,
// predicts each frame report in-bench and compares it with the result channel.
// Depends on lgsc_pkg and the classifier RTL only.

module tb;
    import lgsc_pkg::*;

    localparam int FRAME_WINDOW   = 20;
    localparam int MAX_FRAME_SIDE = 4096;

    typedef struct packed {
        logic [LEVEL_W-1:0]     blue;
        logic [LEVEL_W-1:0]     green;
        logic [LEVEL_W-1:0]     red;
        logic [FRAME_NUM_W-1:0] frame_num;
    } pixel_t;

    typedef struct {
        speed_class_t speed;
        int           max_gaps;
        bit           left_seen;
        bit           right_seen;
    } frame_report_t;

    typedef enum int {
        LANES_NONE, LANES_LEFT, LANES_RIGHT, LANES_BOTH, LANES_NOISE, LANES_RANDOM
    } lane_mix_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [2:0]             cfg_addr = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [LEVEL_W-1:0]     s_blue_level = '0;
    logic [LEVEL_W-1:0]     s_green_level = '0;
    logic [LEVEL_W-1:0]     s_red_level = '0;
    logic [FRAME_NUM_W-1:0] s_frame_number = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [1:0]             m_speed_class;
    logic [COUNT_W-1:0]     m_max_gap_count;
    logic                   m_left_lane_seen;
    logic                   m_right_lane_seen;

    lane_gap_speed_classifier_unit #(
        .FRAME_WINDOW   (FRAME_WINDOW),
        .MAX_FRAME_SIDE (MAX_FRAME_SIDE)
    ) DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_blue_level      (s_blue_level),
        .s_green_level     (s_green_level),
        .s_red_level       (s_red_level),
        .s_frame_number    (s_frame_number),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_speed_class     (m_speed_class),
        .m_max_gap_count   (m_max_gap_count),
        .m_left_lane_seen  (m_left_lane_seen),
        .m_right_lane_seen (m_right_lane_seen)
    );

    // Register copies as the classifier should hold them.
    int cfg_width    = int'(RESET_FRAME_WIDTH);
    int cfg_height   = int'(RESET_FRAME_HEIGHT);
    int cfg_fast_thr = int'(RESET_FAST_GAP_THR);
    int cfg_sat_lim  = int'(RESET_SAT_LIMIT);
    int cfg_val_sens = int'(RESET_VALUE_SENS);

    // Frame tracking state of the classifier.
    int col_pos = 0;
    int row_pos = 0;
    bit left_hit = 1'b0;
    bit right_hit = 1'b0;
    bit left_marked = 1'b1;
    bit right_marked = 1'b1;
    int left_gaps = 0;
    int right_gaps = 0;

    // Raster position of the next pixel to be generated.
    int gen_col = 0;
    int gen_row = 0;

    pixel_t        pixels_pending[$];
    frame_report_t frame_reports[$];
    int            items_queued = 0;
    int            mismatches = 0;
    bit            steady_flow = 1'b0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("lane_gap_speed_classifier_unit verification failed");
        $finish;
    end

    function automatic int side_of(int v, int lo);
        if (v < lo) return lo;
        if (v > MAX_FRAME_SIDE) return MAX_FRAME_SIDE;
        return v;
    endfunction

    // White means low HSV saturation and high value; the rounded saturation
    // 255*(max-min)/max is compared against the limit in cross-multiplied form.
    function automatic bit looks_white(pixel_t px);
        int hi, lo, diff;
        bit sat_ok;
        hi = int'(px.blue);
        lo = int'(px.blue);
        if (int'(px.green) > hi) hi = int'(px.green);
        if (int'(px.red) > hi) hi = int'(px.red);
        if (int'(px.green) < lo) lo = int'(px.green);
        if (int'(px.red) < lo) lo = int'(px.red);
        diff = hi - lo;
        if (hi == 0) sat_ok = cfg_sat_lim > 0;
        else sat_ok = (510 * diff + hi) < (2 * cfg_sat_lim * hi);
        return sat_ok && (hi > 255 - cfg_val_sens);
    endfunction

    task automatic track_pixel(pixel_t px);
        int w, h, half, maxc;
        bit last_col, last_row;
        frame_report_t rep;
        w = side_of(cfg_width, int'(MIN_FRAME_WIDTH));
        h = side_of(cfg_height, int'(MIN_FRAME_HEIGHT));
        half = w / 2;
        last_col = col_pos >= w - 1;
        last_row = row_pos >= h - 1;
        if (row_pos >= h * 2 / 3 && row_pos < h * 4 / 5 && looks_white(px)) begin
            if (col_pos < half) left_hit = 1'b1;
            else if (col_pos < 2 * half) right_hit = 1'b1;
        end
        if (!last_col) begin
            col_pos++;
        end else if (!last_row) begin
            col_pos = 0;
            row_pos++;
        end else begin
            col_pos = 0;
            row_pos = 0;
            rep.left_seen = left_hit;
            rep.right_seen = right_hit;
            // A gap is counted once when a marking disappears, not per missing frame.
            if (!right_hit && right_marked) begin
                right_gaps = (right_gaps < 255) ? right_gaps + 1 : 255;
                right_marked = 1'b0;
            end
            if (right_hit) right_marked = 1'b1;
            if (!left_hit && left_marked) begin
                left_gaps = (left_gaps < 255) ? left_gaps + 1 : 255;
                left_marked = 1'b0;
            end
            if (left_hit) left_marked = 1'b1;
            left_hit = 1'b0;
            right_hit = 1'b0;
            rep.speed = SPEED_UNCHANGED;
            rep.max_gaps = 0;
            if (int'(px.frame_num) % FRAME_WINDOW == 0) begin
                maxc = (right_gaps > left_gaps) ? right_gaps : left_gaps;
                if (maxc == 0) rep.speed = SPEED_SLOW;
                else if (maxc < cfg_fast_thr) rep.speed = SPEED_NORMAL;
                else rep.speed = SPEED_FAST;
                rep.max_gaps = maxc;
                left_gaps = 0;
                right_gaps = 0;
            end
            frame_reports.push_back(rep);
        end
    endtask

    task automatic flag_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge aclk) begin : feed_pixels
        pixel_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                track_pixel('{s_blue_level, s_green_level, s_red_level, s_frame_number});
            if (!s_valid || s_ready) begin
                if (pixels_pending.size() != 0
                        && (steady_flow || $urandom_range(0, 99) >= 13)) begin
                    nxt = pixels_pending.pop_front();
                    s_valid <= 1'b1;
                    s_blue_level <= nxt.blue;
                    s_green_level <= nxt.green;
                    s_red_level <= nxt.red;
                    s_frame_number <= nxt.frame_num;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_reports
        frame_report_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (frame_reports.size() == 0) begin
                    flag_mismatch("unexpected result word, speed_class", -1,
                                  int'(m_speed_class));
                end else begin
                    want = frame_reports.pop_front();
                    if (m_speed_class !== want.speed)
                        flag_mismatch("speed_class", int'(want.speed), int'(m_speed_class));
                    if (m_max_gap_count !== want.max_gaps[COUNT_W-1:0])
                        flag_mismatch("max_gap_count", want.max_gaps, int'(m_max_gap_count));
                    if (m_left_lane_seen !== want.left_seen)
                        flag_mismatch("left_lane_seen", int'(want.left_seen),
                                      int'(m_left_lane_seen));
                    if (m_right_lane_seen !== want.right_seen)
                        flag_mismatch("right_lane_seen", int'(want.right_seen),
                                      int'(m_right_lane_seen));
                end
            end
            m_ready <= steady_flow || $urandom_range(0, 99) >= 13;
        end
    end

    task automatic push_pixel(pixel_t px);
        pixels_pending.push_back(px);
        items_queued++;
    endtask

    // Waits until every word is accepted and every report is back. Pixels inside
    // a frame give no report, so the pipeline is then given time to empty.
    task automatic drain_pipeline();
        while (pixels_pending.size() != 0 || s_valid) @(posedge aclk);
        while (frame_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, int val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val[CFG_DATA_W-1:0];
        case (idx)
            REG_FRAME_WIDTH:  cfg_width = val & 32'h1FFF;
            REG_FRAME_HEIGHT: cfg_height = val & 32'h1FFF;
            REG_FAST_GAP_THR: cfg_fast_thr = val & 32'hFF;
            REG_SAT_LIMIT:    cfg_sat_lim = val & 32'hFF;
            REG_VALUE_SENS:   cfg_val_sens = val & 32'hFF;
            default: ;
        endcase
    endtask

    // The 8-bit registers get random upper bits, which must be dropped.
    task automatic apply_setting(int w, int h, int thr, int sat, int sens);
        drain_pipeline();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_FAST_GAP_THR, thr + 256 * $urandom_range(0, 31));
        write_reg(REG_SAT_LIMIT, sat + 256 * $urandom_range(0, 31));
        write_reg(REG_VALUE_SENS, sens + 256 * $urandom_range(0, 31));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        gen_col = col_pos;
        gen_row = row_pos;
    endtask

    // Queues whole frames, then some extra pixels that leave a frame open.
    // The lane mix decides where white pixels go inside the watched rows.
    task automatic queue_pixels(int frames, int extra, lane_mix_t mix_req, int eval_req);
        int w, h, half, done, extra_left, base;
        bit in_window, want_white, frame_end, eval_now;
        lane_mix_t mix;
        pixel_t px;
        w = side_of(cfg_width, int'(MIN_FRAME_WIDTH));
        h = side_of(cfg_height, int'(MIN_FRAME_HEIGHT));
        half = w / 2;
        done = 0;
        extra_left = extra;
        mix = (mix_req == LANES_RANDOM) ? lane_mix_t'($urandom_range(0, 4)) : mix_req;
        eval_now = (eval_req < 0) ? ($urandom_range(0, 99) < 40) : (eval_req != 0);
        while (done < frames || extra_left > 0) begin
            in_window = gen_row >= h * 2 / 3 && gen_row < h * 4 / 5;
            frame_end = gen_col >= w - 1 && gen_row >= h - 1;
            if (!in_window) begin
                want_white = 1'($urandom_range(0, 1));
            end else begin
                case (mix)
                    LANES_LEFT:  want_white = gen_col < half;
                    LANES_RIGHT: want_white = gen_col >= half;
                    LANES_BOTH:  want_white = 1'b1;
                    LANES_NOISE: want_white = 1'($urandom_range(0, 1));
                    default:     want_white = 1'b0;
                endcase
            end
            if (want_white) begin
                base = int'($urandom_range(150, 255));
                px.blue = LEVEL_W'(base - int'($urandom_range(0, 12)));
                px.green = LEVEL_W'(base - int'($urandom_range(0, 12)));
                px.red = LEVEL_W'(base - int'($urandom_range(0, 12)));
            end else if (in_window && $urandom_range(0, 1) != 0) begin
                px.blue = LEVEL_W'($urandom_range(0, 30));
                px.green = LEVEL_W'($urandom_range(0, 30));
                px.red = LEVEL_W'($urandom_range(180, 255));
            end else if ($urandom_range(0, 9) == 0) begin
                px.blue = {LEVEL_W{1'($urandom_range(0, 1))}};
                px.green = {LEVEL_W{1'($urandom_range(0, 1))}};
                px.red = {LEVEL_W{1'($urandom_range(0, 1))}};
            end else begin
                px.blue = LEVEL_W'($urandom_range(0, 255));
                px.green = LEVEL_W'($urandom_range(0, 255));
                px.red = LEVEL_W'($urandom_range(0, 255));
            end
            px.frame_num = FRAME_NUM_W'($urandom_range(0, 24'hFFFFFF));
            // An odd number is never a multiple of the window length.
            if (frame_end)
                px.frame_num = eval_now
                    ? FRAME_NUM_W'($urandom_range(0, 838860) * FRAME_WINDOW)
                    : (px.frame_num | 24'd1);
            push_pixel(px);
            if (gen_col >= w - 1) begin
                gen_col = 0;
                gen_row = (gen_row >= h - 1) ? 0 : gen_row + 1;
            end else begin
                gen_col++;
            end
            if (done >= frames) begin
                extra_left--;
            end else if (frame_end) begin
                done++;
                mix = (mix_req == LANES_RANDOM) ? lane_mix_t'($urandom_range(0, 4)) : mix_req;
                eval_now = (eval_req < 0) ? ($urandom_range(0, 99) < 40) : (eval_req != 0);
            end
        end
    endtask

    initial begin : stimulus
        pixel_t px;
        int start, step;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A few words at the reset frame size; the frame is cut short below.
        push_pixel('{8'd0, 8'd0, 8'd0, 24'd0});
        push_pixel('{8'd255, 8'd255, 8'd255, 24'hFFFFFF});
        push_pixel('{8'd255, 8'd0, 8'd0, 24'd20});
        push_pixel('{8'd0, 8'd255, 8'd0, 24'd7});
        push_pixel('{8'd0, 8'd0, 8'd255, 24'h800000});
        push_pixel('{8'd128, 8'd128, 8'd128, 24'd40});

        // Shrinking to 2x5 mid-row ends row 0 on the next word. Then the
        // watched row 3 sees a left marking only, evaluated on frame 0, and
        // next a right marking beside a saturated red, on the top frame number.
        apply_setting(2, 5, 4, 70, 130);
        for (int i = 0; i < 19; i++) begin
            px.blue = LEVEL_W'($urandom_range(0, 255));
            px.green = LEVEL_W'($urandom_range(0, 255));
            px.red = LEVEL_W'($urandom_range(0, 255));
            px.frame_num = FRAME_NUM_W'($urandom_range(0, 24'hFFFFFF)) | 24'd1;
            case (i)
                5:  px = '{8'd255, 8'd255, 8'd255, 24'hFFFFFF};
                6:  px = '{8'd0, 8'd0, 8'd0, 24'd0};
                8:  px.frame_num = 24'd0;
                15: px = '{8'd0, 8'd0, 8'd255, 24'd0};
                16: px = '{8'd250, 8'd250, 8'd250, 24'd0};
                18: px.frame_num = 24'hFFFFFF;
                default: ;
            endcase
            push_pixel(px);
        end

        // Random frames over a series of settings, extremes first.
        start = items_queued;
        step = 0;
        while (items_queued - start < 600) begin
            case (step)
                0: apply_setting(3, 5, 0, 70, 130);
                1: apply_setting(1, 4, 1, 255, 255);
                2: apply_setting(0, 0, 255, 0, 0);
                3: apply_setting(5, 13, 2, 128, 200);
                default: apply_setting($urandom_range(0, 9), $urandom_range(0, 8),
                    ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 5),
                    $urandom_range(0, 1) ? $urandom_range(40, 110) : $urandom_range(0, 255),
                    $urandom_range(0, 1) ? $urandom_range(90, 200) : $urandom_range(0, 255));
            endcase
            queue_pixels($urandom_range(3, 8),
                         ($urandom_range(0, 9) < 3) ? $urandom_range(1, 15) : 0,
                         LANES_RANDOM, -1);
            step++;
        end

        // Widest row, clamped, streamed without any idling and left open far
        // past the last column of the next, narrow setting.
        apply_setting(8191, 0, 3, 70, 130);
        steady_flow = 1'b1;
        queue_pixels(0, 150, LANES_BOTH, 1);
        apply_setting(3, 5, 2, 70, 130);
        steady_flow = 1'b0;
        queue_pixels(2, 0, LANES_RANDOM, -1);

        // Tallest frame, clamped, left open far below the last row of the next
        // setting.
        apply_setting(0, 8191, 1, 90, 150);
        queue_pixels(0, 60, LANES_LEFT, 1);
        apply_setting(2, 5, 255, 70, 130);
        queue_pixels(3, 0, LANES_RANDOM, -1);

        // Markings that keep vanishing build up both gap counts.
        apply_setting(2, 5, 3, 70, 130);
        for (int i = 0; i < 5; i++) begin
            queue_pixels(1, 0, LANES_BOTH, 0);
            queue_pixels(1, 0, LANES_NONE, 0);
        end
        queue_pixels(1, 0, LANES_NONE, 1);

        while (pixels_pending.size() != 0 || s_valid) @(posedge aclk);
        while (frame_reports.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && frame_reports.size() == 0) begin
            $display("lane_gap_speed_classifier_unit verification clean");
        end else begin
            $display("lane_gap_speed_classifier_unit verification failed");
        end
        $finish;
    end

endmodule
